// File: rtl/assert_macros.svh
// Assertion macros shared by the LCD nibble sequencer RTL.
// Included by every module that carries concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on the rising clock, ignored while reset is asserted.
`define CLNS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent this cycle implies consequent on the next cycle.
`define CLNS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/clns_pkg.sv
// Shared types, codes and tables for the character LCD nibble sequencer.
// No dependencies; used by every module of the block.
`default_nettype none

package clns_pkg;

	// Request kinds on the func field
	localparam logic [1:0] FUNC_CMD    = 2'd0;
	localparam logic [1:0] FUNC_DATA   = 2'd1;
	localparam logic [1:0] FUNC_CURSOR = 2'd2;
	localparam logic [1:0] FUNC_INIT   = 2'd3;

	// Cursor rows that produce an address command
	localparam logic [1:0] ROW_FIRST  = 2'd1;
	localparam logic [1:0] ROW_SECOND = 2'd2;

	// Register-select levels
	localparam logic RS_CMD  = 1'b0;
	localparam logic RS_DATA = 1'b1;

	// Command constants
	localparam logic [7:0] CURSOR_BASE   = 8'h80;
	localparam logic [7:0] ROW2_OFFSET   = 8'h40;
	localparam logic [3:0] LOW_NIB_MASK  = 4'hF;

	// Hold times
	localparam logic [9:0] HOLD_STROBE  = 10'd1;
	localparam logic [9:0] HOLD_NIBBLE  = 10'd2;
	localparam logic [9:0] HOLD_IDLE    = 10'd30;

	// Power-up command list
	localparam int         INIT_COUNT = 9;
	localparam logic [3:0] INIT_LAST  = 4'(INIT_COUNT - 1);

	// Default depth of the job queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// One unit of work for the back end
	typedef struct packed {
		logic       init;
		logic       rs;
		logic [7:0] data_byte;
	} job_t;

	// Power-up command byte at position idx
	function automatic logic [7:0] init_cmd(input logic [3:0] idx);
		logic [7:0] r;
		case (idx)
			4'd0, 4'd1, 4'd2: r = 8'h03;
			4'd3:             r = 8'h20;
			4'd4:             r = 8'h28;
			4'd5:             r = 8'h08;
			4'd6:             r = 8'h0C;
			4'd7:             r = 8'h06;
			default:          r = 8'h01;
		endcase
		return r;
	endfunction

	// Extra milliseconds after the power-up command at position idx
	function automatic logic [9:0] init_extra(input logic [3:0] idx);
		logic [9:0] r;
		case (idx)
			4'd0, 4'd1, 4'd2:                   r = 10'd5;
			4'd3, 4'd4, 4'd5, 4'd6, 4'd7:       r = 10'd1000;
			default:                            r = 10'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/char_lcd_nibble_sequencer_core.sv
// Character LCD 4-bit bus sequencer. Each request (command byte, data byte, cursor
// position or power-up sequence) becomes a stream of pin-state beats on the output
// channel: data nibble, register select, enable level and a hold time, with last set
// on the request's final beat. A byte request yields 6 beats, a cursor request for
// row 1 or 2 yields 6 beats, a cursor request for any other row yields none, and the
// power-up request yields 55 beats (a 30 ms idle state, then nine commands). The back
// end sequencer emits one beat per cycle while the output is not stalled, and
// consecutive requests follow with no gap; the front end and a job queue (2 entries
// by default) keep taking requests while the back end works through earlier ones.
// Depends on clns_pkg, clns_front, clns_queue and clns_back.
`default_nettype none

module char_lcd_nibble_sequencer_core #(
	parameter int QUEUE_DEPTH = clns_pkg::QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire logic [1:0] func,
	input  wire logic [7:0] value,
	input  wire logic [1:0] row,
	input  wire logic [5:0] column,
	output logic            pin_valid,
	input  wire logic       pin_stall,
	output logic [3:0]      data_nibble,
	output logic            reg_select,
	output logic            enable,
	output logic            hold_is_ms,
	output logic [9:0]      hold_amount,
	output logic            last
);

	clns_pkg::job_t push_job;
	clns_pkg::job_t head_job;
	logic           push;
	logic           pop;
	logic           q_empty;
	logic           q_full;

	// Request decode
	clns_front u_front (
		.valid  (req_valid),
		.stall  (req_stall),
		.func   (func),
		.value  (value),
		.row    (row),
		.column (column),
		.q_full (q_full),
		.push   (push),
		.job    (push_job)
	);

	// Job queue
	clns_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head_job),
		.empty    (q_empty),
		.full     (q_full)
	);

	// Pin-state sequencer
	clns_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_job),
		.q_empty    (q_empty),
		.pop        (pop),
		.out_valid  (pin_valid),
		.out_stall  (pin_stall),
		.out_nibble (data_nibble),
		.out_rs     (reg_select),
		.out_en     (enable),
		.out_ms     (hold_is_ms),
		.out_amount (hold_amount),
		.out_last   (last)
	);

endmodule

`default_nettype wire

// File: rtl/clns_front.sv
// Front end: classifies requests into byte or power-up jobs and pushes those that yield one.
// Depends on clns_pkg; drives the job queue.
`default_nettype none

module clns_front (
	input  wire logic                valid,
	output logic                     stall,
	input  wire logic [1:0]          func,
	input  wire logic [7:0]          value,
	input  wire logic [1:0]          row,
	input  wire logic [5:0]          column,
	input  wire logic                q_full,
	output logic                     push,
	output clns_pkg::job_t           job
);

	logic [7:0] col8;
	logic [7:0] row1_addr;
	logic [7:0] row2_addr;
	logic       has_job;

	// Cursor address in 8 bits with wraparound
	assign col8      = {2'b00, column};
	assign row1_addr = 8'(col8 - 8'd1);
	assign row2_addr = 8'(clns_pkg::ROW2_OFFSET + col8 - 8'd1);

	// Decode the request into a job
	always_comb begin
		job     = '0;
		has_job = 1'b1;
		unique case (func)
			clns_pkg::FUNC_CMD: begin
				job.rs        = clns_pkg::RS_CMD;
				job.data_byte = value;
			end
			clns_pkg::FUNC_DATA: begin
				job.rs        = clns_pkg::RS_DATA;
				job.data_byte = value;
			end
			clns_pkg::FUNC_CURSOR: begin
				job.rs = clns_pkg::RS_CMD;
				if (row == clns_pkg::ROW_FIRST) begin
					job.data_byte = clns_pkg::CURSOR_BASE | row1_addr;
				end else if (row == clns_pkg::ROW_SECOND) begin
					job.data_byte = clns_pkg::CURSOR_BASE | row2_addr;
				end else begin
					has_job = 1'b0;
				end
			end
			default: begin
				job.init = 1'b1;
				job.rs   = clns_pkg::RS_CMD;
			end
		endcase
	end

	// Requests that yield nothing are still taken, just not queued
	assign stall = q_full;
	assign push  = valid && !q_full && has_job;

endmodule

`default_nettype wire

// File: rtl/clns_queue.sv
// Short job queue between the front and back ends.
// Depends on clns_pkg for the job type and the assertion macros.
`default_nettype none
`include "assert_macros.svh"

module clns_queue #(
	parameter int DEPTH = clns_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire clns_pkg::job_t push_job,
	input  wire logic           pop,
	output clns_pkg::job_t      head,
	output logic                empty,
	output logic                full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	clns_pkg::job_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign head  = mem_q[rd_ptr_q];

	// Entry storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
			end
		end
	end

	`CLNS_ASSERT(a_no_overflow, clk, arst_n, !(push && full && !pop), "queue push while full")
	`CLNS_ASSERT(a_no_underflow, clk, arst_n, !(pop && empty), "queue pop while empty")
	`CLNS_ASSERT_NEXT(a_push_fills, clk, arst_n, push && !pop, !empty, "queue empty after push")

endmodule

`default_nettype wire

// File: rtl/clns_back.sv
// Back end: walks each job through its pin states into the output register.
// Depends on clns_pkg for tables and job type, and on the assertion macros.
`default_nettype none
`include "assert_macros.svh"

module clns_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire clns_pkg::job_t head,
	input  wire logic           q_empty,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [3:0]          out_nibble,
	output logic                out_rs,
	output logic                out_en,
	output logic                out_ms,
	output logic [9:0]          out_amount,
	output logic                out_last
);

	// Pin-state positions within one byte
	localparam logic [2:0] STEP_HI_SETUP = 3'd0;
	localparam logic [2:0] STEP_HI_STROBE = 3'd1;
	localparam logic [2:0] STEP_HI_HOLD  = 3'd2;
	localparam logic [2:0] STEP_LO_SETUP = 3'd3;
	localparam logic [2:0] STEP_LO_STROBE = 3'd4;
	localparam logic [2:0] STEP_LO_HOLD  = 3'd5;

	// Current job and position
	logic       busy_q;
	logic       init_q;
	logic       idle_q;
	logic       rs_q;
	logic [7:0] byte_q;
	logic [3:0] idx_q;
	logic [2:0] step_q;

	// Output register
	logic       valid_q;
	logic [3:0] nib_q;
	logic       rs_out_q;
	logic       en_q;
	logic       ms_q;
	logic [9:0] amt_q;
	logic       last_q;

	logic       slot_free;
	logic       emit;
	logic       final_state;
	logic [7:0] cur_byte;
	logic [3:0] cur_nib;
	logic       cur_en;
	logic       cur_ms;
	logic [9:0] cur_amt;
	logic [9:0] extra;

	assign slot_free = !valid_q || !out_stall;
	assign emit      = busy_q && slot_free;

	// Pin state for the current position
	assign cur_byte    = init_q ? clns_pkg::init_cmd(idx_q) : byte_q;
	assign extra       = init_q ? clns_pkg::init_extra(idx_q) : '0;
	assign final_state = !idle_q && (step_q == STEP_LO_HOLD)
			&& (!init_q || (idx_q == clns_pkg::INIT_LAST));

	always_comb begin
		cur_nib = cur_byte[7:4];
		cur_en  = 1'b0;
		cur_ms  = 1'b0;
		cur_amt = clns_pkg::HOLD_STROBE;
		case (step_q)
			STEP_HI_SETUP: ;
			STEP_HI_STROBE: cur_en = 1'b1;
			STEP_HI_HOLD: begin
				cur_ms  = 1'b1;
				cur_amt = clns_pkg::HOLD_NIBBLE;
			end
			STEP_LO_SETUP: cur_nib = cur_byte[3:0] & clns_pkg::LOW_NIB_MASK;
			STEP_LO_STROBE: begin
				cur_nib = cur_byte[3:0] & clns_pkg::LOW_NIB_MASK;
				cur_en  = 1'b1;
			end
			default: begin
				cur_nib = cur_byte[3:0] & clns_pkg::LOW_NIB_MASK;
				cur_ms  = 1'b1;
				cur_amt = 10'(clns_pkg::HOLD_NIBBLE + extra);
			end
		endcase
	end

	// Take the next job when idle, or right behind the final state of this one
	assign pop = !q_empty && (!busy_q || (emit && final_state));

	// Sequencer position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			init_q <= 1'b0;
			idle_q <= 1'b0;
			rs_q   <= 1'b0;
			byte_q <= '0;
			idx_q  <= '0;
			step_q <= STEP_HI_SETUP;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				init_q <= head.init;
				idle_q <= head.init;
				rs_q   <= head.rs;
				byte_q <= head.data_byte;
				idx_q  <= '0;
				step_q <= STEP_HI_SETUP;
			end else if (emit) begin
				if (final_state) begin
					busy_q <= 1'b0;
				end else if (idle_q) begin
					idle_q <= 1'b0;
				end else if (step_q == STEP_LO_HOLD) begin
					step_q <= STEP_HI_SETUP;
					idx_q  <= 4'(idx_q + 1'b1);
				end else begin
					step_q <= 3'(step_q + 1'b1);
				end
			end
		end
	end

	// Output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (idle_q) begin
				nib_q    <= '0;
				rs_out_q <= clns_pkg::RS_CMD;
				en_q     <= 1'b0;
				ms_q     <= 1'b1;
				amt_q    <= clns_pkg::HOLD_IDLE;
				last_q   <= 1'b0;
			end else begin
				nib_q    <= cur_nib;
				rs_out_q <= init_q ? clns_pkg::RS_CMD : rs_q;
				en_q     <= cur_en;
				ms_q     <= cur_ms;
				amt_q    <= cur_amt;
				last_q   <= final_state;
			end
		end
	end

	assign out_valid  = valid_q;
	assign out_nibble = nib_q;
	assign out_rs     = rs_out_q;
	assign out_en     = en_q;
	assign out_ms     = ms_q;
	assign out_amount = amt_q;
	assign out_last   = last_q;

	`CLNS_ASSERT(a_strobe_short, clk, arst_n, !(valid_q && en_q) || (!ms_q && amt_q == clns_pkg::HOLD_STROBE), "enable high beat must hold one cycle")
	`CLNS_ASSERT(a_last_in_ms, clk, arst_n, !(valid_q && last_q) || (ms_q && !en_q), "final beat must be a low-enable millisecond hold")
	`CLNS_ASSERT_NEXT(a_final_ends_job, clk, arst_n, emit && final_state && q_empty, !busy_q, "sequencer still busy after final beat")

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for char_lcd_nibble_sequencer_core.
// Predicts the pin-state beats of each request and compares them beat by beat.
// Depends on clns_pkg and the RTL of the sequencer only.
`timescale 1ns / 1ps

module testbench;

	// One pin state as seen on the output channel
	typedef struct packed {
		logic [3:0] nibble;
		logic       rs;
		logic       en;
		logic       is_ms;
		logic [9:0] amount;
		logic       fin;
	} pin_state_t;

	// Expected pin states of the LCD bus, oldest first
	class lcd_pin_scoreboard;
		pin_state_t expected_pins[$];
		int         errors;

		function new();
			errors = 0;
		endfunction

		// Three states per nibble: strobe setup, strobe high, settle in ms
		function void add_nibble(input logic [3:0] nib, input logic rs,
				input logic [9:0] tail_ms);
			expected_pins.push_back('{nib, rs, 1'b0, 1'b0, clns_pkg::HOLD_STROBE, 1'b0});
			expected_pins.push_back('{nib, rs, 1'b1, 1'b0, clns_pkg::HOLD_STROBE, 1'b0});
			expected_pins.push_back('{nib, rs, 1'b0, 1'b1, tail_ms, 1'b0});
		endfunction

		// High nibble first; the extra wait lands on the final settle hold
		function void add_byte(input logic [7:0] b, input logic rs, input logic [9:0] extra);
			add_nibble(b[7:4], rs, clns_pkg::HOLD_NIBBLE);
			add_nibble(b[3:0], rs, clns_pkg::HOLD_NIBBLE + extra);
		endfunction

		function void note_request(input logic [1:0] f, input logic [7:0] v,
				input logic [1:0] r, input logic [5:0] c);
			logic [7:0] power_cmds [9];
			logic [9:0] power_waits [9];
			int         start_size;
			logic [7:0] addr;
			power_cmds  = '{8'h03, 8'h03, 8'h03, 8'h20, 8'h28, 8'h08, 8'h0C, 8'h06, 8'h01};
			power_waits = '{10'd5, 10'd5, 10'd5, 10'd1000, 10'd1000, 10'd1000,
				10'd1000, 10'd1000, 10'd0};
			start_size = expected_pins.size();
			case (f)
				clns_pkg::FUNC_CMD:  add_byte(v, clns_pkg::RS_CMD, 10'd0);
				clns_pkg::FUNC_DATA: add_byte(v, clns_pkg::RS_DATA, 10'd0);
				clns_pkg::FUNC_CURSOR: begin
					// Address math wraps in 8 bits, column zero included
					if (r == clns_pkg::ROW_FIRST) begin
						addr = clns_pkg::CURSOR_BASE | (8'(c) - 8'd1);
						add_byte(addr, clns_pkg::RS_CMD, 10'd0);
					end else if (r == clns_pkg::ROW_SECOND) begin
						addr = clns_pkg::CURSOR_BASE | (clns_pkg::ROW2_OFFSET + 8'(c) - 8'd1);
						add_byte(addr, clns_pkg::RS_CMD, 10'd0);
					end
				end
				default: begin
					expected_pins.push_back('{4'h0, clns_pkg::RS_CMD, 1'b0, 1'b1,
						clns_pkg::HOLD_IDLE, 1'b0});
					for (int i = 0; i < 9; i++)
						add_byte(power_cmds[i], clns_pkg::RS_CMD, power_waits[i]);
				end
			endcase
			if (expected_pins.size() > start_size)
				expected_pins[expected_pins.size() - 1].fin = 1'b1;
		endfunction

		function void compare_field(input string name, input int exp_v, input int act_v);
			if (exp_v != act_v) begin
				errors++;
				$display("%0t: mismatch on %s: expected %0d, actual %0d",
					$time, name, exp_v, act_v);
			end
		endfunction

		function void check_pin(input pin_state_t got);
			pin_state_t want;
			if (expected_pins.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat: expected none, actual %h", $time, got);
				return;
			end
			want = expected_pins.pop_front();
			compare_field("data_nibble", want.nibble, got.nibble);
			compare_field("reg_select", want.rs, got.rs);
			compare_field("enable", want.en, got.en);
			compare_field("hold_is_ms", want.is_ms, got.is_ms);
			compare_field("hold_amount", want.amount, got.amount);
			compare_field("last", want.fin, got.fin);
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_stall;
	logic [1:0] func;
	logic [7:0] value;
	logic [1:0] row;
	logic [5:0] column;
	logic       pin_valid;
	logic       pin_stall;
	logic [3:0] data_nibble;
	logic       reg_select;
	logic       enable;
	logic       hold_is_ms;
	logic [9:0] hold_amount;
	logic       last;

	lcd_pin_scoreboard sb = new();

	bit quiet_tail;
	bit long_hold_go;
	bit long_hold_done;

	char_lcd_nibble_sequencer_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.func        (func),
		.value       (value),
		.row         (row),
		.column      (column),
		.pin_valid   (pin_valid),
		.pin_stall   (pin_stall),
		.data_nibble (data_nibble),
		.reg_select  (reg_select),
		.enable      (enable),
		.hold_is_ms  (hold_is_ms),
		.hold_amount (hold_amount),
		.last        (last)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watch both channels at the edge: note accepted requests, check accepted beats
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				sb.note_request(func, value, row, column);
			if (pin_valid && !pin_stall)
				sb.check_pin('{data_nibble, reg_select, enable, hold_is_ms,
					hold_amount, last});
		end
	end

	// Offer one request and hold it until the block takes it
	task automatic send_request(input logic [1:0] f, input logic [7:0] v,
			input logic [1:0] r, input logic [5:0] c, input bit gappy);
		int gap;
		if (gappy && !quiet_tail && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		func      <= f;
		value     <= v;
		row       <= r;
		column    <= c;
		do @(posedge clk); while (req_stall);
	endtask

	// Random request, mostly byte and cursor traffic with an occasional power-up
	task automatic send_random(input bit gappy);
		logic [1:0] f;
		logic [5:0] c;
		f = 2'($urandom_range(0, 2));
		if ($urandom_range(0, 15) == 0)
			f = clns_pkg::FUNC_INIT;
		c = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(1, 40));
		send_request(f, 8'($urandom), 2'($urandom_range(0, 3)), c, gappy);
	endtask

	// Request side: reset, directed corners, then random traffic
	initial begin
		bit gappy;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		func      <= clns_pkg::FUNC_CMD;
		value     <= 8'h00;
		row       <= 2'd0;
		column    <= 6'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Byte extremes
		send_request(clns_pkg::FUNC_CMD, 8'h00, 2'd0, 6'd1, 1'b0);
		send_request(clns_pkg::FUNC_CMD, 8'hFF, 2'd3, 6'd63, 1'b0);
		send_request(clns_pkg::FUNC_DATA, 8'h00, 2'd0, 6'd0, 1'b0);
		send_request(clns_pkg::FUNC_DATA, 8'hFF, 2'd1, 6'd40, 1'b0);
		send_request(clns_pkg::FUNC_DATA, 8'h5A, 2'd2, 6'd21, 1'b0);
		send_request(clns_pkg::FUNC_CMD, 8'hA5, 2'd1, 6'd42, 1'b0);
		// Cursor on both rows, first and last column, column zero and overflow
		send_request(clns_pkg::FUNC_CURSOR, 8'h00, clns_pkg::ROW_FIRST, 6'd1, 1'b0);
		send_request(clns_pkg::FUNC_CURSOR, 8'hFF, clns_pkg::ROW_FIRST, 6'd40, 1'b0);
		send_request(clns_pkg::FUNC_CURSOR, 8'h00, clns_pkg::ROW_FIRST, 6'd0, 1'b0);
		send_request(clns_pkg::FUNC_CURSOR, 8'h00, clns_pkg::ROW_FIRST, 6'd63, 1'b0);
		send_request(clns_pkg::FUNC_CURSOR, 8'h00, clns_pkg::ROW_SECOND, 6'd1, 1'b0);
		send_request(clns_pkg::FUNC_CURSOR, 8'h00, clns_pkg::ROW_SECOND, 6'd40, 1'b0);
		send_request(clns_pkg::FUNC_CURSOR, 8'h00, clns_pkg::ROW_SECOND, 6'd0, 1'b0);
		send_request(clns_pkg::FUNC_CURSOR, 8'h00, clns_pkg::ROW_SECOND, 6'd63, 1'b0);
		// Rows that yield nothing, back to back with real work
		send_request(clns_pkg::FUNC_CURSOR, 8'h00, 2'd0, 6'd5, 1'b0);
		send_request(clns_pkg::FUNC_CURSOR, 8'hFF, 2'd3, 6'd40, 1'b0);
		send_request(clns_pkg::FUNC_DATA, 8'h3C, 2'd0, 6'd1, 1'b0);
		send_request(clns_pkg::FUNC_CURSOR, 8'h00, 2'd0, 6'd1, 1'b0);
		// Power-up sequence
		send_request(clns_pkg::FUNC_INIT, 8'h00, 2'd0, 6'd0, 1'b0);
		send_request(clns_pkg::FUNC_CMD, 8'h01, 2'd0, 6'd1, 1'b0);

		// Random traffic; idling switched per chunk of 25 requests
		gappy = 1'b0;
		for (int n = 0; n < 205; n++) begin
			if (n % 25 == 0)
				gappy = ($urandom_range(0, 2) != 0);
			if (n == 60)
				long_hold_go = 1'b1;
			if (n == 170)
				quiet_tail = 1'b1;
			send_random(gappy);
		end
		req_valid <= 1'b0;

		// Drain, then give stray beats a chance to show up
		while (sb.expected_pins.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Result side: random stall bursts, one long hold-off while requests keep coming
	initial begin
		bit stall_mode;
		int hold;
		int span;
		pin_stall <= 1'b0;
		stall_mode = 1'b1;
		span = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			span++;
			if (span >= 150) begin
				span = 0;
				stall_mode = ($urandom_range(0, 2) != 0);
			end
			if (long_hold_go && !long_hold_done) begin
				long_hold_done = 1'b1;
				pin_stall <= 1'b1;
				hold = 0;
				while (hold < 400) begin
					@(posedge clk);
					hold++;
				end
				pin_stall <= 1'b0;
			end else if (stall_mode && !quiet_tail && $urandom_range(0, 4) == 0) begin
				pin_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				pin_stall <= 1'b0;
			end
		end
	end

	// Watchdog
	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/clns_pkg.sv
rtl/clns_front.sv
rtl/clns_queue.sv
rtl/clns_back.sv
rtl/char_lcd_nibble_sequencer_core.sv
tb/sv/testbench.sv
